[src/u16u8_pkg.sv]
// Shared types, constants and encode helpers for the UTF-16 to UTF-8 transcoder.
// Used by the front, queue, back and top-level modules; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package u16u8_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;
	localparam logic [15:0] REPL_CP        = 16'hFFFD;
	localparam logic [15:0] SURR_MASK      = 16'hFC00;
	localparam logic [15:0] HIGH_SURR      = 16'hD800;
	localparam logic [15:0] LOW_SURR       = 16'hDC00;
	localparam logic [20:0] SUPP_BASE      = 21'h10000;
	localparam logic [15:0] LEN_MAX        = 16'hFFFF;

	// Configuration register indexes
	localparam logic REG_COUNT_ONLY = 1'b0;
	localparam logic REG_CAPACITY   = 1'b1;

	// One queued job: up to two code points and an optional terminator
	typedef struct packed {
		logic        a_en;
		logic [20:0] a_cp;
		logic        b_en;
		logic [15:0] b_cp;
		logic        term;
		logic        term_valid;
		logic [15:0] total_length;
	} entry_t;

	// Outcome of handling one code point against the length state
	typedef struct packed {
		logic        emit;
		logic [15:0] cnt;
		logic        stopped;
	} handle_t;

	// Number of UTF-8 bytes for a code point
	function automatic logic [2:0] cp_len(input logic [20:0] cp);
		logic [2:0] n;
		if (cp <= 21'h7F) begin
			n = 3'd1;
		end else if (cp <= 21'h7FF) begin
			n = 3'd2;
		end else if (cp <= 21'hFFFF) begin
			n = 3'd3;
		end else begin
			n = 3'd4;
		end
		return n;
	endfunction

	// Byte k of the UTF-8 sequence for cp
	function automatic logic [7:0] enc_byte(input logic [20:0] cp, input logic [1:0] k);
		logic [7:0] b;
		logic [2:0] n;
		n = cp_len(cp);
		b = 8'h00;
		case (n)
			3'd1: begin
				b = cp[7:0];
			end
			3'd2: begin
				b = (k == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
			end
			3'd3: begin
				case (k)
					2'd0:    b = {4'b1110, cp[15:12]};
					2'd1:    b = {2'b10, cp[11:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
			default: begin
				case (k)
					2'd0:    b = {5'b11110, cp[20:18]};
					2'd1:    b = {2'b10, cp[17:12]};
					2'd2:    b = {2'b10, cp[11:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
		endcase
		return b;
	endfunction

	// Fit test / length update for one sequence
	function automatic handle_t handle_cp(input logic [2:0] len, input logic [15:0] cnt,
			input logic stopped, input logic count_only, input logic [15:0] capacity);
		handle_t    r;
		logic [16:0] sum;
		logic [16:0] need;
		sum  = {1'b0, cnt} + 17'(len);
		need = sum + 17'd1;
		r.emit    = 1'b0;
		r.cnt     = cnt;
		r.stopped = stopped;
		if (!stopped) begin
			if (count_only) begin
				r.cnt = sum[16] ? LEN_MAX : sum[15:0];
			end else if (need > {1'b0, capacity}) begin
				r.stopped = 1'b1;
			end else begin
				r.emit = 1'b1;
				r.cnt  = sum[15:0];
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[src/utf16_to_utf8_transcoder.sv]
// UTF-16 to UTF-8 transcoder. The first result passes through the job queue, then the output
// byte register after its unit is accepted. Results leave at one per cycle while out_ready
// does not stall them; a unit causes 1 to 6 bytes, and the output byte register sets that rate.
// Units causing no result take no queue entry; units are taken every cycle while the queue has room.
// Reset clears the string state, empties the queue and sets count_only to 0, capacity to 65535.
// Depends on u16u8_pkg, u16u8_front, u16u8_queue and u16u8_back.
`timescale 1ns / 1ps
`default_nettype none

module utf16_to_utf8_transcoder #(
	parameter int QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [15:0] code_unit,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [7:0]  out_byte,
	output logic        byte_valid,
	output logic        run_last,
	output logic        string_end,
	output logic [15:0] total_length,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire         cfg_index,
	input  wire  [15:0] cfg_data
);

	logic              count_only_q;
	logic [15:0]       capacity_q;
	logic              q_push, q_pop, q_empty, q_full;
	u16u8_pkg::entry_t q_wdata, q_head;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_only_q <= 1'b0;
			capacity_q   <= u16u8_pkg::CAPACITY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				u16u8_pkg::REG_COUNT_ONLY: count_only_q <= cfg_data[0];
				u16u8_pkg::REG_CAPACITY:   capacity_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	u16u8_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.code_unit  (code_unit),
		.count_only (count_only_q),
		.capacity   (capacity_q),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_data     (q_wdata)
	);

	u16u8_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty),
		.full      (q_full)
	);

	u16u8_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (q_head),
		.q_empty      (q_empty),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.byte_valid   (byte_valid),
		.run_last     (run_last),
		.string_end   (string_end),
		.total_length (total_length)
	);

endmodule

`default_nettype wire

[src/u16u8_front.sv]
// Front end: accepts code units, pairs surrogates, tracks length and builds jobs.
// Depends on u16u8_pkg; feeds u16u8_queue.
`timescale 1ns / 1ps
`default_nettype none

module u16u8_front (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      in_valid,
	output logic                     in_ready,
	input  wire  [15:0]              code_unit,
	input  wire                      count_only,
	input  wire  [15:0]              capacity,
	input  wire                      q_full,
	output logic                     q_push,
	output u16u8_pkg::entry_t        q_data
);

	logic        high_pending_q;
	logic [9:0]  high_bits_q;
	logic [15:0] byte_count_q;
	logic        stopped_q;

	logic        is_high, is_low, is_zero, accept;
	logic [20:0] cp1;
	u16u8_pkg::handle_t r1, r2;
	logic [15:0] cnt1, cnt2;
	logic        stop1, stop2;
	logic        do2, b_handle, set_pend;
	logic [15:0] b_cp;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// Classify the unit
	assign is_high = (code_unit & u16u8_pkg::SURR_MASK) == u16u8_pkg::HIGH_SURR;
	assign is_low  = (code_unit & u16u8_pkg::SURR_MASK) == u16u8_pkg::LOW_SURR;
	assign is_zero = code_unit == 16'h0000;

	// First sequence: the held high surrogate, paired or replaced
	assign cp1 = is_low ? (21'({high_bits_q, code_unit[9:0]}) + u16u8_pkg::SUPP_BASE)
	                    : 21'(u16u8_pkg::REPL_CP);
	assign r1    = u16u8_pkg::handle_cp(u16u8_pkg::cp_len(cp1), byte_count_q, stopped_q,
	                                    count_only, capacity);
	assign cnt1  = high_pending_q ? r1.cnt : byte_count_q;
	assign stop1 = high_pending_q ? r1.stopped : stopped_q;

	// Second sequence: the unit itself
	assign do2      = !(high_pending_q && is_low);
	assign b_cp     = is_low ? u16u8_pkg::REPL_CP : code_unit;
	assign b_handle = do2 && !is_zero && !is_high;
	assign r2       = u16u8_pkg::handle_cp(u16u8_pkg::cp_len(21'(b_cp)), cnt1, stop1,
	                                       count_only, capacity);
	assign cnt2     = b_handle ? r2.cnt : cnt1;
	assign stop2    = b_handle ? r2.stopped : stop1;
	assign set_pend = do2 && is_high && !stop1;

	// Job for the back end
	always_comb begin
		q_data.a_en         = high_pending_q && r1.emit;
		q_data.a_cp         = cp1;
		q_data.b_en         = b_handle && r2.emit;
		q_data.b_cp         = b_cp;
		q_data.term         = do2 && is_zero;
		q_data.term_valid   = !count_only && (cnt1 < capacity);
		q_data.total_length = cnt1;
	end

	assign q_push = accept && (q_data.a_en || q_data.b_en || q_data.term);

	// String state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_pending_q <= 1'b0;
			high_bits_q    <= '0;
			byte_count_q   <= '0;
			stopped_q      <= 1'b0;
		end else if (accept) begin
			if (q_data.term) begin
				high_pending_q <= 1'b0;
				high_bits_q    <= '0;
				byte_count_q   <= '0;
				stopped_q      <= 1'b0;
			end else begin
				high_pending_q <= set_pend;
				if (set_pend) begin
					high_bits_q <= code_unit[9:0];
				end
				byte_count_q <= cnt2;
				stopped_q    <= stop2;
			end
		end
	end

endmodule

`default_nettype wire

[src/u16u8_queue.sv]
// Short job queue between the front and back ends.
// Depends on u16u8_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none

module u16u8_queue #(
	parameter int DEPTH = u16u8_pkg::QUEUE_DEPTH
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      push,
	input  u16u8_pkg::entry_t        push_data,
	input  wire                      pop,
	output u16u8_pkg::entry_t        head,
	output logic                     empty,
	output logic                     full
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	u16u8_pkg::entry_t mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;

	assign empty = count_q == '0;
	assign full  = count_q == CW'(DEPTH);
	assign head  = mem_q[rd_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[src/u16u8_back.sv]
// Back end: walks the head job and issues one UTF-8 byte per cycle while out_ready does not stall it.
// Depends on u16u8_pkg; reads from u16u8_queue.
`timescale 1ns / 1ps
`default_nettype none

module u16u8_back (
	input  wire                      clk,
	input  wire                      arst_n,
	input  u16u8_pkg::entry_t        head,
	input  wire                      q_empty,
	output logic                     q_pop,
	output logic                     out_valid,
	input  wire                      out_ready,
	output logic [7:0]               out_byte,
	output logic                     byte_valid,
	output logic                     run_last,
	output logic                     string_end,
	output logic [15:0]              total_length
);

	logic [2:0] idx_q;
	logic [2:0] la, lb, lab, n, kb;
	logic       in_a, in_b, last, load;
	logic [7:0] nbyte;

	// Position of the current byte within the job
	assign la   = head.a_en ? u16u8_pkg::cp_len(head.a_cp) : 3'd0;
	assign lb   = head.b_en ? u16u8_pkg::cp_len(21'(head.b_cp)) : 3'd0;
	assign lab  = la + lb;
	assign n    = lab + 3'(head.term);
	assign kb   = idx_q - la;
	assign in_a = idx_q < la;
	assign in_b = !in_a && (idx_q < lab);
	assign last = idx_q == (n - 3'd1);

	always_comb begin
		if (in_a) begin
			nbyte = u16u8_pkg::enc_byte(head.a_cp, idx_q[1:0]);
		end else if (in_b) begin
			nbyte = u16u8_pkg::enc_byte(21'(head.b_cp), kb[1:0]);
		end else begin
			nbyte = 8'h00;
		end
	end

	assign load  = !q_empty && (!out_valid || out_ready);
	assign q_pop = load && last;

	// Output register and byte index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			idx_q     <= '0;
		end else begin
			if (load) begin
				out_valid <= 1'b1;
				idx_q     <= last ? 3'd0 : idx_q + 3'd1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte     <= nbyte;
			byte_valid   <= (in_a || in_b) ? 1'b1 : head.term_valid;
			run_last     <= last;
			string_end   <= !in_a && !in_b;
			total_length <= (!in_a && !in_b) ? head.total_length : 16'h0000;
		end
	end

endmodule

`default_nettype wire
